>>> hdl/mpkt_pkg.sv
// shared types and constants for the max_profit_k_trades block
// no dependencies; imported by mpkt_slot and max_profit_k_trades
`default_nettype none

package mpkt_pkg;

    // default sizing of the block
    localparam int DEF_MAX_TRADES  = 16;
    localparam int DEF_PRICE_BITS  = 30;
    localparam int DEF_PROFIT_BITS = 48;

    // trade limit register
    localparam int              LIMIT_BITS  = 5;
    localparam [LIMIT_BITS-1:0] LIMIT_RESET = 5'd1;

    // per-slot control from the top level
    typedef struct packed {
        logic update;   // slot takes its next values
        logic clear;    // series ended, return slot to empty
    } slot_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/mpkt_slot.sv
// one trade slot: best cash while holding and while free after this trade
// depends on mpkt_pkg for the default sizes and the slot control struct
`default_nettype none

module mpkt_slot #(
    parameter int PRICE_BITS  = mpkt_pkg::DEF_PRICE_BITS,
    parameter int PROFIT_BITS = mpkt_pkg::DEF_PROFIT_BITS
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  mpkt_pkg::slot_ctrl_t        ctrl,
    input  wire  [PRICE_BITS-1:0]       price,
    input  wire  [PROFIT_BITS-1:0]      free_before,   // free cash of the previous slot
    output logic [PROFIT_BITS-1:0]      free_cash,     // current free cash
    output logic [PROFIT_BITS-1:0]      free_cash_next // value after this price
);
    import mpkt_pkg::*;

    localparam int WIDEST    = (PROFIT_BITS > PRICE_BITS) ? PROFIT_BITS : PRICE_BITS;
    localparam int HOLD_BITS = WIDEST + 2;

    logic signed [HOLD_BITS-1:0] hold_reg, hold_next;
    logic                        hold_ok_reg;
    logic [PROFIT_BITS-1:0]      free_reg;

    logic signed [HOLD_BITS-1:0] price_s, before_s, buy_cand;
    logic signed [HOLD_BITS:0]   sell_sum;
    logic [PROFIT_BITS-1:0]      sell_val;

    localparam logic signed [HOLD_BITS:0] PROFIT_MAX_W =
        {{(HOLD_BITS + 1 - PROFIT_BITS){1'b0}}, {PROFIT_BITS{1'b1}}};

    always_comb begin
        price_s  = signed'({{(HOLD_BITS - PRICE_BITS){1'b0}}, price});
        before_s = signed'({{(HOLD_BITS - PROFIT_BITS){1'b0}}, free_before});
        buy_cand = before_s - price_s;

        if (!hold_ok_reg || buy_cand > hold_reg) begin
            hold_next = buy_cand;
        end else begin
            hold_next = hold_reg;
        end

        // sell the held unit, clamped to the profit range
        sell_sum = {hold_reg[HOLD_BITS-1], hold_reg} + {price_s[HOLD_BITS-1], price_s};
        if (sell_sum[HOLD_BITS]) begin
            sell_val = '0;
        end else if (sell_sum > PROFIT_MAX_W) begin
            sell_val = '1;
        end else begin
            sell_val = sell_sum[PROFIT_BITS-1:0];
        end

        if (hold_ok_reg && sell_val > free_reg) begin
            free_cash_next = sell_val;
        end else begin
            free_cash_next = free_reg;
        end
    end

    assign free_cash = free_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ok_reg <= 1'b0;
            free_reg    <= '0;
        end else if (ctrl.clear) begin
            hold_ok_reg <= 1'b0;
            free_reg    <= '0;
        end else if (ctrl.update) begin
            hold_ok_reg <= 1'b1;
            free_reg    <= free_cash_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.update) begin
            hold_reg <= hold_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/max_profit_k_trades.sv
// top level of the max_profit_k_trades block: input register, trade slots, result register
// depends on mpkt_pkg and mpkt_slot
`default_nettype none

// Takes one price per transfer on the s_ stream and returns on the m_ stream,
// through the input register and the result register, the best profit reachable
// so far in the series with at most trade_limit buy-then-sell trades (saturating
// at the top of the profit range). Every trade slot updates in parallel, so the
// block sustains one price per clock while the result stream is not stalled;
// m_tvalid rises once the price has passed through the input register and the
// result register. A price with s_tlast set closes the series: its result
// carries m_tlast and all slots return to empty. trade_limit is to be written on
// the cfg_ port only while the block is idle; the block itself does not enforce it.
// Zero gives a profit of zero, values above MAX_TRADES act as MAX_TRADES.

module max_profit_k_trades #(
    parameter int MAX_TRADES  = mpkt_pkg::DEF_MAX_TRADES,
    parameter int PRICE_BITS  = mpkt_pkg::DEF_PRICE_BITS,
    parameter int PROFIT_BITS = mpkt_pkg::DEF_PROFIT_BITS,
    localparam int IN_TDATA_W  = ((PRICE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((PROFIT_BITS + 7) / 8) * 8
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // configuration write
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [mpkt_pkg::LIMIT_BITS-1:0] cfg_data,    // trade_limit
    // price stream
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [IN_TDATA_W-1:0]           s_tdata,     // price, zero padding
    input  wire                             s_tlast,     // last_price
    // result stream
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [OUT_TDATA_W-1:0]          m_tdata,     // best_profit, zero padding
    output logic                            m_tlast      // series_done
);
    import mpkt_pkg::*;

    localparam int IDX_BITS = (MAX_TRADES > 1) ? $clog2(MAX_TRADES) : 1;

    // trade limit register
    logic [LIMIT_BITS-1:0] trade_limit_reg;

    // input register
    logic                  in_valid_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic                  last_reg;

    // result register
    logic                   out_valid_reg;
    logic [PROFIT_BITS-1:0] best_reg;
    logic                   done_reg;

    logic                   advance;     // the result register can take a new value
    logic                   s_xfer;
    slot_ctrl_t             slot_ctrl;
    logic [IDX_BITS-1:0]    sel_idx;
    logic [PROFIT_BITS-1:0] best_next;

    logic [PROFIT_BITS-1:0] free_cash      [MAX_TRADES];
    logic [PROFIT_BITS-1:0] free_cash_next [MAX_TRADES];

    // config is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trade_limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            trade_limit_reg <= cfg_data;
        end
    end

    // handshake: the input register refills while the result waits, stalls only
    // when both registers are full and the result is not taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            price_reg <= s_tdata[PRICE_BITS-1:0];
            last_reg  <= s_tlast;
        end
    end

    // slots move on when the item in the input register goes to the result register
    always_comb begin
        slot_ctrl.update = in_valid_reg && advance;
        slot_ctrl.clear  = in_valid_reg && advance && last_reg;
    end

    // trade slot chain: each slot buys with the free cash its predecessor had
    for (genvar j = 0; j < MAX_TRADES; j++) begin : g_slot
        logic [PROFIT_BITS-1:0] prev_free;

        if (j == 0) begin : g_first
            assign prev_free = '0;
        end else begin : g_rest
            assign prev_free = free_cash[j-1];
        end

        mpkt_slot #(
            .PRICE_BITS  (PRICE_BITS),
            .PROFIT_BITS (PROFIT_BITS)
        ) u_slot (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctrl           (slot_ctrl),
            .price          (price_reg),
            .free_before    (prev_free),
            .free_cash      (free_cash[j]),
            .free_cash_next (free_cash_next[j])
        );
    end

    // pick the slot of the trade limit, clamped to the slots built
    always_comb begin
        if (32'(trade_limit_reg) > 32'(MAX_TRADES)) begin
            sel_idx = IDX_BITS'(MAX_TRADES - 1);
        end else begin
            sel_idx = IDX_BITS'(int'(trade_limit_reg) - 1);
        end

        if (trade_limit_reg == '0) begin
            best_next = '0;
        end else begin
            best_next = free_cash_next[sel_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_ctrl.update) begin
            best_reg <= best_next;
            done_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(best_reg);
    assign m_tlast  = done_reg;

endmodule

`default_nettype wire

>>> hdl/mpkt_checker.sv
// port-level checks for max_profit_k_trades, bound to the top level
// depends on the top level's ports only
`default_nettype none

module mpkt_checker #(
    parameter int OUT_TDATA_W = 48
) (
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   s_tvalid,
    input wire                   s_tready,
    input wire                   m_tvalid,
    input wire                   m_tready,
    input wire [OUT_TDATA_W-1:0] m_tdata,
    input wire                   m_tlast
);

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // with no result pending the block always takes a price
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a price taken with the output idle shows a result once through the input and result registers
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |-> ##2 m_tvalid)
        else $error("accepted price produced no result");

endmodule

bind max_profit_k_trades mpkt_checker #(
    .OUT_TDATA_W (OUT_TDATA_W)
) u_mpkt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/max_profit_k_trades_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for max_profit_k_trades: prices in, best profit per price out
// depends on mpkt_pkg and the max_profit_k_trades rtl; no files or arguments needed

module max_profit_k_trades_tb;

    localparam int     SLOTS        = mpkt_pkg::DEF_MAX_TRADES;
    localparam int     PRICE_W      = mpkt_pkg::DEF_PRICE_BITS;
    localparam int     PROFIT_W     = mpkt_pkg::DEF_PROFIT_BITS;
    localparam int     LIMIT_W      = mpkt_pkg::LIMIT_BITS;
    localparam int     IN_W         = ((PRICE_W + 7) / 8) * 8;
    localparam int     OUT_W        = ((PROFIT_W + 7) / 8) * 8;
    localparam longint PRICE_TOP    = (64'd1 << PRICE_W) - 1;
    localparam longint PROFIT_TOP   = (64'd1 << PROFIT_W) - 1;
    localparam int     RANDOM_ITEMS = 900;
    localparam int     STALL_LIMIT  = 2000;   // cycles with no transfer at all
    localparam int     SETTLE       = 4;      // result register latency plus margin

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               last;
    } price_item_t;

    typedef struct packed {
        logic [PROFIT_W-1:0] profit;
        logic                done;
    } profit_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata   = '0;   // price, zero padding
    logic               s_tlast   = 1'b0; // last_price
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [OUT_W-1:0]   m_tdata;          // best_profit, zero padding
    logic               m_tlast;          // series_done

    max_profit_k_trades DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // trade slot state as predicted: cash while holding, cash while free
    logic signed [PROFIT_W+1:0] hold_cash  [SLOTS];
    bit                         hold_valid [SLOTS];
    logic [PROFIT_W-1:0]        free_cash  [SLOTS];
    logic [LIMIT_W-1:0]         trade_limit;

    price_item_t price_queue[$];
    profit_t     expected_profits[$];
    int          sent_items  = 0;   // prices put on the bus by the driver
    int          taken_items = 0;   // prices seen to transfer by the monitor
    int          send_calm   = 0;
    int          recv_calm   = 0;
    int          errors      = 0;
    int          quiet_count = 0;

    function automatic void clear_slots();
        for (int j = 0; j < SLOTS; j++) begin
            hold_cash[j]  = '0;
            hold_valid[j] = 1'b0;
            free_cash[j]  = '0;
        end
    endfunction

    // all slots move together from their old values; result is the free cash
    // after trade_limit trades, clamped to the number of slots
    function automatic profit_t next_best_profit(logic [PRICE_W-1:0] price, logic last);
        logic signed [PROFIT_W+1:0] nh [SLOTS];
        logic [PROFIT_W-1:0]        nf [SLOTS];
        longint                     p, base_cash, cand, sold, h;
        int                         lim;
        profit_t                    res;
        p = longint'({34'd0, price});
        for (int j = 0; j < SLOTS; j++) begin
            if (j == 0)
                base_cash = 0;
            else
                base_cash = longint'({16'd0, free_cash[j-1]});
            cand = base_cash - p;
            if (!hold_valid[j] || cand > longint'(hold_cash[j]))
                nh[j] = cand[PROFIT_W+1:0];
            else
                nh[j] = hold_cash[j];
            sold = longint'({16'd0, free_cash[j]});
            if (hold_valid[j]) begin
                h = longint'(hold_cash[j]) + p;
                if (h > PROFIT_TOP)
                    h = PROFIT_TOP;
                else if (h < 0)
                    h = 0;
                if (h > sold)
                    sold = h;
            end
            nf[j] = sold[PROFIT_W-1:0];
        end
        for (int j = 0; j < SLOTS; j++) begin
            hold_cash[j]  = nh[j];
            hold_valid[j] = 1'b1;
            free_cash[j]  = nf[j];
        end
        lim = (int'(trade_limit) > SLOTS) ? SLOTS : int'(trade_limit);
        res.profit = (lim == 0) ? '0 : free_cash[lim-1];
        res.done   = last;
        if (last)
            clear_slots();
        return res;
    endfunction

    // random gaps, with the odd long stretch of full throughput
    function automatic bit take_break(inout int calm);
        if (calm > 0) begin
            calm--;
            return 1'b0;
        end
        if ($urandom_range(399) == 0) begin
            calm = 300;
            return 1'b0;
        end
        return $urandom_range(99) < 35;
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (sent_items == taken_items) begin
                if (price_queue.size() != 0 && !take_break(send_calm)) begin
                    s_tvalid   <= 1'b1;
                    s_tdata    <= {{(IN_W-PRICE_W){1'b0}}, price_queue[0].price};
                    s_tlast    <= price_queue[0].last;
                    sent_items <= sent_items + 1;
                    void'(price_queue.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !take_break(recv_calm);
        end
    end

    // monitor: transfers are sampled on the rising edge
    always @(posedge aclk) begin
        profit_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_profits.push_back(next_best_profit(s_tdata[PRICE_W-1:0], s_tlast));
                taken_items <= taken_items + 1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_profits.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got profit %0d done %0b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = expected_profits.pop_front();
                    if (m_tdata[PROFIT_W-1:0] !== want.profit) begin
                        $display("%0t: best_profit expected %0d, got %0d",
                                 $time, want.profit, m_tdata[PROFIT_W-1:0]);
                        errors++;
                    end
                    if (m_tlast !== want.done) begin
                        $display("%0t: series_done expected %0b, got %0b",
                                 $time, want.done, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_LIMIT) begin
            $display("[max_profit_k_trades] ERROR");
            $finish;
        end
    end

    task automatic add_price(input longint price, input bit last);
        price_item_t item;
        item.price = price[PRICE_W-1:0];
        item.last  = last;
        price_queue.push_back(item);
    endtask

    // wait until every price has gone in and every result has come back
    task automatic drain_results();
        while (price_queue.size() != 0 || sent_items != taken_items ||
               expected_profits.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_limit(input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[LIMIT_W-1:0];
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        trade_limit = value[LIMIT_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int     limit_plan[$];
        int     sent, phase_no, phase_len, series_len, style, k;
        longint level;

        limit_plan  = '{1, 16, 0, 31, 17, 2, 8, 5};
        trade_limit = mpkt_pkg::LIMIT_RESET;
        clear_slots();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // limit left at its reset value, price extremes
        add_price(5, 0);
        add_price(3, 0);
        add_price(9, 0);
        add_price(0, 0);
        add_price(PRICE_TOP, 1);
        drain_results();

        // every slot in use, full-swing zigzag
        write_limit(16);
        for (int i = 0; i < 8; i++)
            add_price((i % 2) ? PRICE_TOP : 0, i == 7);
        drain_results();

        // zero trades allowed; series left open across the next write
        write_limit(0);
        add_price(10, 0);
        add_price(1000, 0);
        drain_results();

        // limit above the slot count, changed mid-series
        write_limit(31);
        add_price(500, 0);
        add_price(20, 0);
        add_price(900, 1);
        drain_results();

        // two trades on a classic up-down series
        write_limit(2);
        add_price(7, 0);
        add_price(1, 0);
        add_price(5, 0);
        add_price(3, 0);
        add_price(6, 0);
        add_price(4, 1);
        drain_results();

        // random series; a phase may end mid-series so the next limit applies at once
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase_no < limit_plan.size())
                write_limit(limit_plan[phase_no]);
            else
                write_limit($urandom_range(31));
            phase_no++;
            phase_len = $urandom_range(120, 40);
            k = 0;
            while (k < phase_len) begin
                series_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(40, 2);
                style      = $urandom_range(3);
                level      = $urandom_range(PRICE_TOP);
                for (int i = 0; i < series_len && k < phase_len; i++) begin
                    case (style)
                        0: begin
                            level = $urandom_range(PRICE_TOP);
                        end
                        1: begin
                            level = $urandom_range(255);
                        end
                        2: begin
                            // random walk, clamped to the price range
                            level = level + longint'($urandom_range(2000)) - 1000;
                            if (level < 0)
                                level = 0;
                            else if (level > PRICE_TOP)
                                level = PRICE_TOP;
                        end
                        default: begin
                            level = PRICE_TOP - longint'($urandom_range(255));
                        end
                    endcase
                    k++;
                    add_price(level, i == series_len - 1);
                end
            end
            sent += k;
            drain_results();
        end

        if (errors == 0)
            $display("[max_profit_k_trades] OK");
        else
            $display("[max_profit_k_trades] ERROR");
        $finish;
    end

endmodule
